// ===== src/quaternion_body_to_world_pose_core_assert.svh =====
// Assertion macros for the pose core.
`ifndef QUATERNION_BODY_TO_WORLD_POSE_CORE_ASSERT_SVH
`define QUATERNION_BODY_TO_WORLD_POSE_CORE_ASSERT_SVH
`define QBW_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define QBW_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/qbw_pkg.sv =====
package qbw_pkg;
  localparam int AtanIterations = 16;
  localparam int AtanTableLen = 24;
  localparam logic signed [63:0] OneQ28 = 64'sd268435456;
  localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;
  localparam logic signed [31:0] PiQ13 = 32'sd25736;
  localparam logic signed [31:0] TwoPiQ13 = 32'sd51472;
  localparam logic [14:0] TolReset = 15'd3277;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] bx, by, bz;
    logic signed [15:0] hd;
    logic signed [31:0] vx, vy;
    logic               replaced;
  } qbw_job_t;

  function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
    logic signed [63:0] r;
    case (i)
      5'd0: r = 64'sd843314857;  5'd1: r = 64'sd497837829;
      5'd2: r = 64'sd263043837;  5'd3: r = 64'sd133525159;
      5'd4: r = 64'sd67021687;   5'd5: r = 64'sd33543516;
      5'd6: r = 64'sd16775851;   5'd7: r = 64'sd8388437;
      5'd8: r = 64'sd4194283;    5'd9: r = 64'sd2097149;
      default: r = (i < 5'd24) ? (64'sd1 <<< (30 - i)) : 64'sd0;
    endcase
    return r;
  endfunction
endpackage

// ===== src/qbw_if.sv =====
interface qbw_in_if;
  logic valid, ready;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0] body_x, body_y, body_z;
  logic signed [15:0] heading;
  logic signed [31:0] vehicle_x, vehicle_y;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, body_x, body_y, body_z,
                 heading, vehicle_x, vehicle_y, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, body_x, body_y, body_z,
               heading, vehicle_x, vehicle_y, output ready);
endinterface

interface qbw_out_if;
  logic valid, ready;
  logic signed [31:0] world_x, world_y;
  logic signed [15:0] world_heading;
  logic quat_replaced;
  modport source(output valid, world_x, world_y, world_heading, quat_replaced,
                 input ready);
  modport sink(input valid, world_x, world_y, world_heading, quat_replaced,
               output ready);
endinterface

interface qbw_cfg_if;
  logic valid, ready;
  logic [14:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== src/qbw_front.sv =====
// Front: squared norm check by squaring each of the four components in turn, quaternion swap.
module qbw_front import qbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qbw_in_if.sink      in_ch,
  input  logic [14:0] tol,
  output logic        job_valid,
  input  logic        job_ready,
  output qbw_job_t    job
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_CMP = 3'd2, S_OUT = 3'd3;
  logic [2:0] state;
  logic [1:0] idx;
  logic signed [63:0] acc;
  logic signed [15:0] lw, lx, ly, lz;
  logic signed [15:0] opnd;
  logic signed [31:0] sq;
  logic signed [63:0] dev;

  assign in_ch.ready = (state == S_IDLE);
  assign job_valid = (state == S_OUT);

  always_comb begin
    case (idx)
      2'd0: opnd = job.qw;
      2'd1: opnd = job.qx;
      2'd2: opnd = job.qy;
      default: opnd = job.qz;
    endcase
  end
  assign sq = opnd * opnd;
  assign dev = (acc - OneQ28 < 0) ? OneQ28 - acc : acc - OneQ28;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= 2'd0;
      lw <= '0; lx <= '0; ly <= '0; lz <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          job.qw <= in_ch.quat_w; job.qx <= in_ch.quat_x;
          job.qy <= in_ch.quat_y; job.qz <= in_ch.quat_z;
          job.bx <= in_ch.body_x; job.by <= in_ch.body_y; job.bz <= in_ch.body_z;
          job.hd <= in_ch.heading;
          job.vx <= in_ch.vehicle_x; job.vy <= in_ch.vehicle_y;
          acc <= '0;
          idx <= 2'd0;
          state <= S_SQ;
        end
        S_SQ: begin
          acc <= acc + 64'(sq);
          idx <= idx + 2'd1;
          if (idx == 2'd3) state <= S_CMP;
        end
        S_CMP: begin
          if (dev > $signed({35'd0, tol, 14'd0})) begin
            job.replaced <= 1'b1;
            job.qw <= lw; job.qx <= lx; job.qy <= ly; job.qz <= lz;
          end else begin
            job.replaced <= 1'b0;
            lw <= job.qw; lx <= job.qx; ly <= job.qy; lz <= job.qz;
          end
          state <= S_OUT;
        end
        S_OUT: if (job_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/qbw_fifo.sv =====
// Two-entry job queue between front and back.
module qbw_fifo import qbw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  qbw_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output qbw_job_t rd_data
);
  qbw_job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;
  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== src/qbw_back.sv =====
// Back: quaternion products and dot products on two multipliers, then CORDIC (skipped for a zero yaw vector).
module qbw_back import qbw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  output logic     job_ready,
  input  qbw_job_t job,
  qbw_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DOT = 3'd2, S_CPRE = 3'd3,
                         S_CORD = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6;
  logic [2:0] state;
  logic [4:0] step;
  qbw_job_t j;
  logic signed [31:0] p [10];
  logic signed [63:0] r [6];
  logic signed [63:0] acc;
  logic signed [63:0] cx, cy, cz;
  logic signed [15:0] ma, mb;
  logic signed [31:0] mprod;
  // matrix terms fit in 20 bits, so the dot product multiplier is 20x32
  logic signed [19:0] da;
  logic signed [31:0] db;
  logic signed [51:0] dprod;
  logic signed [63:0] xs, ys, yw, sum;
  logic signed [63:0] wsum;
  logic signed [63:0] yny, ydx;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                              input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // products: ww xx yy zz xy wz xz wy yz wx
  always_comb begin
    case (step[3:0])
      4'd0: begin ma = j.qw; mb = j.qw; end
      4'd1: begin ma = j.qx; mb = j.qx; end
      4'd2: begin ma = j.qy; mb = j.qy; end
      4'd3: begin ma = j.qz; mb = j.qz; end
      4'd4: begin ma = j.qx; mb = j.qy; end
      4'd5: begin ma = j.qw; mb = j.qz; end
      4'd6: begin ma = j.qx; mb = j.qz; end
      4'd7: begin ma = j.qw; mb = j.qy; end
      4'd8: begin ma = j.qy; mb = j.qz; end
      default: begin ma = j.qw; mb = j.qx; end
    endcase
  end
  assign mprod = ma * mb;

  always_comb begin
    case (step[2:0])
      3'd0: begin da = r[0][19:0]; db = j.bx; end
      3'd1: begin da = r[1][19:0]; db = j.by; end
      3'd2: begin da = r[2][19:0]; db = j.bz; end
      3'd3: begin da = r[3][19:0]; db = j.bx; end
      3'd4: begin da = r[4][19:0]; db = j.by; end
      default: begin da = r[5][19:0]; db = j.bz; end
    endcase
  end
  assign dprod = da * db;

  // yaw vector: 2(zw + xy), 2(w^2 + x^2) - 1
  assign yny = 2 * (64'(p[5]) + 64'(p[4]));
  assign ydx = 2 * (64'(p[0]) + 64'(p[1])) - OneQ28;

  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign yw = rnd(cz, 17) + 64'(j.hd);
  assign wsum = (yw < -64'(PiQ13)) ? yw + 64'(TwoPiQ13) :
                (yw > 64'(PiQ13)) ? yw - 64'(TwoPiQ13) : yw;
  assign sum = acc + 64'(dprod);

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign job_ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      case (state)
        S_IDLE: if (job_valid) begin
          j <= job; step <= '0; state <= S_MUL;
        end
        S_MUL: begin
          p[step[3:0]] <= mprod;
          if (step == 5'd9) begin step <= '0; state <= S_CPRE; end
          else step <= step + 5'd1;
        end
        S_CPRE: begin
          r[0] <= rnd(64'(p[0]) + 64'(p[1]) - 64'(p[2]) - 64'(p[3]), 14);
          r[1] <= rnd(2 * (64'(p[4]) - 64'(p[5])), 14);
          r[2] <= rnd(2 * (64'(p[6]) + 64'(p[7])), 14);
          r[3] <= rnd(2 * (64'(p[4]) + 64'(p[5])), 14);
          r[4] <= rnd(64'(p[0]) - 64'(p[1]) + 64'(p[2]) - 64'(p[3]), 14);
          r[5] <= rnd(2 * (64'(p[8]) - 64'(p[9])), 14);
          acc <= '0; step <= '0;
          state <= S_DOT;
        end
        S_DOT: begin
          if (step == 5'd2) begin
            out_ch.world_x <= sat(64'(j.vx) + rnd(sum, 14)); acc <= '0;
          end else acc <= sum;
          if (step == 5'd5) begin
            out_ch.world_y <= sat(64'(j.vy) + rnd(sum, 14));
            step <= '0;
            if (yny == 0 && ydx == 0) begin
              cx <= '0; cy <= '0; cz <= '0; state <= S_FIN;
            end else begin
              if (ydx < 0) begin
                if (yny >= 0) begin cx <= yny; cy <= -ydx; cz <= HalfPiQ30; end
                else begin cx <= -yny; cy <= ydx; cz <= -HalfPiQ30; end
              end else begin cx <= ydx; cy <= yny; cz <= '0; end
              state <= S_CORD;
            end
          end else step <= step + 5'd1;
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + atan_entry(step);
          end else begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - atan_entry(step);
          end
          if (32'(step) == AtanIterations - 1 || 32'(step) == AtanTableLen - 1)
            state <= S_FIN;
          else step <= step + 5'd1;
        end
        S_FIN: begin
          out_ch.world_heading <= wsum[15:0];
          out_ch.quat_replaced <= j.replaced;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/quaternion_body_to_world_pose_core.sv =====
// Path of a word: front norm check, queue, back load, quaternion products, matrix
// round, dot steps and CORDIC steps; no CORDIC when the yaw vector is zero.
// The front takes new words while the back works, until the queue is full; the
// back loop bounds the rate.
// Reset (rst, synchronous): stored quaternion zero, tolerance 3277, queue empty.
`include "quaternion_body_to_world_pose_core_assert.svh"
module quaternion_body_to_world_pose_core import qbw_pkg::*; (
  input logic clk,
  input logic rst,
  qbw_in_if.sink    in_ch,
  qbw_out_if.source out_ch,
  qbw_cfg_if.sink   cfg
);
  logic [14:0] tol;
  logic f_valid, f_ready, b_valid, b_ready;
  qbw_job_t f_job, b_job;

  // tolerance register, always writable
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) tol <= TolReset;
    else if (cfg.valid) tol <= cfg.data;
  end

  qbw_front u_front (.clk, .rst, .in_ch, .tol, .job_valid(f_valid),
                     .job_ready(f_ready), .job(f_job));
  qbw_fifo u_fifo (.clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
                   .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job));
  qbw_back u_back (.clk, .rst, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
                   .out_ch);

  // a stalled result word must hold; the check covers valid and world_x
  `QBW_ASSERT_NXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready,
                  out_ch.valid && $stable(out_ch.world_x))
  // queue hands a job only when it holds one
  `QBW_ASSERT_IMP(a_q_ok, clk, rst, b_valid && b_ready, b_valid)
endmodule

// ===== dv/tb_quaternion_body_to_world_pose_core.sv =====
module tb_quaternion_body_to_world_pose_core;
  import qbw_pkg::*;

  // Expected output word of the pose core.
  typedef struct {
    logic signed [31:0] wx, wy;
    logic signed [15:0] whd;
    logic               rep;
  } pose_word_t;

  // Scoreboard: keeps its own copy of tolerance and stored quaternion,
  // predicts each accepted word and compares outputs in order.
  class pose_scoreboard;
    logic [14:0]        tol;
    logic signed [15:0] held [4];
    pose_word_t         pending [$];
    int                 errors;
    int                 n_checked;
    int                 n_replaced;

    function void clear();
      tol = TolReset;
      foreach (held[k]) held[k] = '0;
      pending.delete();
    endfunction

    // floor division by 2^s
    function automatic longint fl_shr(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint rnd_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // CORDIC vectoring atan2, Q4.28 in, Q3.13 out
    function automatic longint yaw_q13(longint ny, longint dx);
      longint x, y, z, t, xs, ys;
      x = dx; y = ny; z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = HalfPiQ30;
        end else begin
          t = x; x = -y; y = t; z = -HalfPiQ30;
        end
      end
      for (int i = 0; i < AtanIterations && i < AtanTableLen; i++) begin
        xs = fl_shr(x, i); ys = fl_shr(y, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_entry(5'(i));
        end else begin
          x -= ys; y += xs; z -= atan_entry(5'(i));
        end
      end
      return rnd_shr(z, 17);
    endfunction

    function void note_input(logic signed [15:0] qi [4], logic signed [31:0] b [3],
                             logic signed [15:0] hd, logic signed [31:0] vx,
                             logic signed [31:0] vy);
      longint q[4], n, dev, r[6], acc, yaw;
      pose_word_t w;
      foreach (q[k]) q[k] = qi[k];
      n = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
      dev = n - OneQ28;
      if (dev < 0) dev = -dev;
      w.rep = dev > (longint'(tol) <<< 14);
      if (w.rep) foreach (q[k]) q[k] = held[k];
      foreach (held[k]) held[k] = 16'(q[k]);
      r[0] = rnd_shr(q[0]*q[0] + q[1]*q[1] - q[2]*q[2] - q[3]*q[3], 14);
      r[1] = rnd_shr(2 * (q[1]*q[2] - q[0]*q[3]), 14);
      r[2] = rnd_shr(2 * (q[1]*q[3] + q[0]*q[2]), 14);
      r[3] = rnd_shr(2 * (q[1]*q[2] + q[0]*q[3]), 14);
      r[4] = rnd_shr(q[0]*q[0] - q[1]*q[1] + q[2]*q[2] - q[3]*q[3], 14);
      r[5] = rnd_shr(2 * (q[2]*q[3] - q[0]*q[1]), 14);
      acc = r[0]*longint'(b[0]) + r[1]*longint'(b[1]) + r[2]*longint'(b[2]);
      w.wx = 32'(clip32(longint'(vx) + rnd_shr(acc, 14)));
      acc = r[3]*longint'(b[0]) + r[4]*longint'(b[1]) + r[5]*longint'(b[2]);
      w.wy = 32'(clip32(longint'(vy) + rnd_shr(acc, 14)));
      yaw = yaw_q13(2 * (q[3]*q[0] + q[1]*q[2]), 2 * (q[0]*q[0] + q[1]*q[1]) - OneQ28);
      yaw += hd;
      if (yaw < -PiQ13) yaw += TwoPiQ13;
      if (yaw > PiQ13) yaw -= TwoPiQ13;
      w.whd = yaw[15:0];
      pending = {pending, w};
    endfunction

    function void check_output(logic signed [31:0] wx, logic signed [31:0] wy,
                               logic signed [15:0] whd, logic rep);
      pose_word_t e;
      if (pending.size() == 0) begin
        $error("output word with no prediction pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (rep) n_replaced++;
      if (wx !== e.wx) begin
        $error("world_x expected %0d actual %0d", e.wx, wx); errors++;
      end
      if (wy !== e.wy) begin
        $error("world_y expected %0d actual %0d", e.wy, wy); errors++;
      end
      if (whd !== e.whd) begin
        $error("world_heading expected %0d actual %0d", e.whd, whd); errors++;
      end
      if (rep !== e.rep) begin
        $error("quat_replaced expected %0d actual %0d", e.rep, rep); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  qbw_in_if  in_ch();
  qbw_out_if out_ch();
  qbw_cfg_if cfg();

  quaternion_body_to_world_pose_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  pose_scoreboard sb;
  int send_idle_pct;   // sender gap chance, percent
  int recv_idle_pct;   // receiver stall chance, percent
  int hold_cycles;     // long receiver hold-off, counted by the sink process
  int n_sent;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0; in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0;
    in_ch.body_x = '0; in_ch.body_y = '0; in_ch.body_z = '0;
    in_ch.heading = '0; in_ch.vehicle_x = '0; in_ch.vehicle_y = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
  end

  // Output side: checks each accepted word, random stalls, plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_output(out_ch.world_x, out_ch.world_y, out_ch.world_heading,
                        out_ch.quat_replaced);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one word; gaps before it at the sender idle rate.
  // valid stays high after the handshake; the next gap, a tolerance write or the end of the test drops it.
  task automatic send_pose(logic signed [15:0] q [4], logic signed [31:0] b [3],
                           logic signed [15:0] hd, logic signed [31:0] vx,
                           logic signed [31:0] vy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.quat_w <= q[0]; in_ch.quat_x <= q[1];
    in_ch.quat_y <= q[2]; in_ch.quat_z <= q[3];
    in_ch.body_x <= b[0]; in_ch.body_y <= b[1]; in_ch.body_z <= b[2];
    in_ch.heading <= hd; in_ch.vehicle_x <= vx; in_ch.vehicle_y <= vy;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(q, b, hd, vx, vy);
    n_sent++;
  endtask

  // Tolerance write, only with the core drained.
  task automatic write_tolerance(logic [14:0] t);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= t;
    do @(posedge clk); while (!cfg.ready);
    sb.tol = t;
    cfg.valid <= 1'b0;
  endtask

  // Random quaternion: mostly near unit, sometimes wild.
  task automatic rand_quat(output logic signed [15:0] q [4]);
    real a, bb, c, d, s;
    int kind;
    kind = $urandom_range(9);
    if (kind < 7) begin
      a = $urandom_range(2000) - 1000.0; bb = $urandom_range(2000) - 1000.0;
      c = $urandom_range(2000) - 1000.0; d = $urandom_range(2000) - 1000.0;
      s = $sqrt(a*a + bb*bb + c*c + d*d);
      if (s < 1.0) s = 1.0;
      q[0] = 16'($rtoi(a / s * 16384.0) + $signed($urandom_range(200)) - 100);
      q[1] = 16'($rtoi(bb / s * 16384.0));
      q[2] = 16'($rtoi(c / s * 16384.0));
      q[3] = 16'($rtoi(d / s * 16384.0));
    end else begin
      foreach (q[k]) q[k] = 16'($urandom());
    end
  endtask

  task automatic rand_pose();
    logic signed [15:0] q [4];
    logic signed [31:0] b [3];
    logic signed [15:0] hd;
    logic signed [31:0] vx, vy;
    rand_quat(q);
    foreach (b[k]) b[k] = ($urandom_range(3) == 0) ? $urandom()
                                                   : $signed($urandom_range(20000000)) - 10000000;
    hd = 16'($signed($urandom_range(51472)) - 25736);
    vx = ($urandom_range(4) == 0) ? $urandom() : $signed($urandom_range(2000000)) - 1000000;
    vy = ($urandom_range(4) == 0) ? $urandom() : $signed($urandom_range(2000000)) - 1000000;
    send_pose(q, b, hd, vx, vy);
  endtask

  initial begin
    logic signed [15:0] q [4];
    logic signed [31:0] b [3];
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    n_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bad first quaternion uses the zero stored one (yaw pi).
    q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    b = '{32'sh7fffffff, 32'sh80000000, 32'sd65536};
    send_pose(q, b, 16'sd0, 32'sh7fffffff, 32'sh80000000);
    // Identity, zero yaw plus heading extremes.
    q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    b = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
    send_pose(q, b, 16'sd25736, 32'sh7fffffff, 32'sh7fffffff);
    send_pose(q, b, -16'sd25736, 32'sh80000000, 32'sh80000000);
    // Yaw of pi: vector on negative x axis.
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_pose(q, b, 16'sd25736, 32'sd0, 32'sd0);
    // 90 deg about z and its negative; heading out of range wraps once.
    q = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
    send_pose(q, b, 16'sh7fff, 32'sd100, -32'sd100);
    q = '{16'sd11585, 16'sd0, 16'sd0, -16'sd11585};
    send_pose(q, b, 16'sh8000, 32'sd0, 32'sd0);
    // Zero yaw: roll of 90 deg about x.
    q = '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
    send_pose(q, b, 16'sd0, 32'sd0, 32'sd0);
    // Most negative components: replaced by the stored good one.
    q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_pose(q, b, 16'sd1, 32'sd0, 32'sd0);

    // Tolerance extremes, each with a few random words.
    write_tolerance(15'd0);
    repeat (6) rand_pose();
    write_tolerance(15'd16384);
    repeat (6) rand_pose();
    write_tolerance(15'h7fff);
    repeat (6) rand_pose();
    write_tolerance(TolReset);

    // Long output hold-off while the sender keeps offering.
    hold_cycles = 2000;
    repeat (8) rand_pose();

    send_idle_pct = 35; recv_idle_pct = 55;
    repeat (420) rand_pose();
    write_tolerance(15'($urandom_range(16384)));
    send_idle_pct = 55; recv_idle_pct = 35;
    repeat (400) rand_pose();
    write_tolerance(15'($urandom_range(1000)));
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (400) rand_pose();
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d pose words sent, %0d results checked, %0d with replaced quaternion",
             n_sent, sb.n_checked, sb.n_replaced);
    $display("covered tolerance extremes, wraparound, saturation and output hold-off");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== quaternion_body_to_world_pose_core.f =====
+incdir+src
src/qbw_pkg.sv
src/qbw_if.sv
src/qbw_front.sv
src/qbw_fifo.sv
src/qbw_back.sv
src/quaternion_body_to_world_pose_core.sv
dv/tb_quaternion_body_to_world_pose_core.sv
